// ===== rtl/wildcard_glob_matcher_defines.svh =====
// Assertion helpers for the glob matcher.
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

// Property that must hold at every edge outside reset.
`define GWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define GWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gwm_pkg.sv =====
`default_nettype none
package gwm_pkg;

  localparam int unsigned SymW = 16;

  localparam logic [SymW-1:0] StarChar = 16'h002A;
  localparam logic [SymW-1:0] AnyChar  = 16'h003F;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_SUBJECT = 2'd2,
    OP_END     = 2'd3
  } gwm_op_e;

  // What one pattern cell reports for the current subject character.
  typedef struct packed {
    logic star;     // cell holds '*'
    logic step_ok;  // cell is '?' or equals the subject character
  } gwm_cell_t;

endpackage
`default_nettype wire

// ===== rtl/gwm_cell.sv =====
`default_nettype none
module gwm_cell import gwm_pkg::*; (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [SymW-1:0] wr_sym_i,
  input  logic [SymW-1:0] subj_sym_i,
  output gwm_cell_t       cell_o
);

  logic [SymW-1:0] sym_q;
  logic            star_q;
  logic            any_q;

  // Class flags are decoded once at load time.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      sym_q  <= wr_sym_i;
      star_q <= (wr_sym_i == StarChar);
      any_q  <= (wr_sym_i == AnyChar);
    end
  end

  assign cell_o.star    = star_q;
  assign cell_o.step_ok = any_q || (sym_q == subj_sym_i);

endmodule
`default_nettype wire

// ===== rtl/gwm_closure.sv =====
`default_nettype none
module gwm_closure import gwm_pkg::*; #(
  parameter int unsigned Depth = 64
) (
  input  logic [Depth:0]   act_i,
  input  logic [Depth-1:0] hop_i,
  output logic [Depth:0]   act_o
);

  // Star runs let a position slide forward; done as a log-depth prefix scan.
  localparam int unsigned Levels = ($clog2(Depth + 1) < 1) ? 1 : $clog2(Depth + 1);

  logic [Depth:0] act_lvl [Levels+1];
  logic [Depth:0] run_lvl [Levels+1];

  assign act_lvl[0] = act_i;
  assign run_lvl[0] = {1'b0, hop_i};

  for (genvar l = 0; l < Levels; l++) begin : g_lvl
    localparam int unsigned Dist = 1 << l;
    for (genvar k = 0; k <= Depth; k++) begin : g_pos
      if (k >= Dist) begin : g_far
        assign act_lvl[l+1][k] = act_lvl[l][k] || (act_lvl[l][k-Dist] && run_lvl[l][k-Dist]);
      end else begin : g_near
        assign act_lvl[l+1][k] = act_lvl[l][k];
      end
      // run_lvl[l][j]: positions j .. j+2^l-1 are all live stars
      if (k + Dist <= Depth) begin : g_run
        assign run_lvl[l+1][k] = run_lvl[l][k] && run_lvl[l][k+Dist];
      end else begin : g_run_end
        assign run_lvl[l+1][k] = 1'b0;
      end
    end
  end

  assign act_o = act_lvl[Levels];

endmodule
`default_nettype wire

// ===== rtl/wildcard_glob_matcher.sv =====
// Channel   Dir  Payload                                   Beats
// s_axis    in   tdata: symbol; tuser: opcode               one per command or character
// m_axis    out  tdata: matched; tuser: pattern_overflow    one per end-of-subject beat
//
// Each input beat waits in the input register while the update logic runs;
// a new beat is accepted every cycle, so throughput is one beat per clock while no
// result stalls; an end-of-subject result goes from the input to the output register.
// The pattern cells and the star-run prefix scan set the update path depth.
// Reset clears control state at once; no clearing pass is needed.
// A stalled result holds back only an end-of-subject beat and the beats behind it.
`default_nettype none
`include "wildcard_glob_matcher_defines.svh"
module wildcard_glob_matcher import gwm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [SymW-1:0] s_axis_tdata,   // [15:0] symbol
  input  logic [1:0]      s_axis_tuser,   // [1:0] opcode
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [0] matched, [7:1] zero
  output logic [0:0]      m_axis_tuser    // [0] pattern_overflow
);

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);

  logic            in_valid_q;
  gwm_op_e         in_op_q;
  logic [SymW-1:0] in_sym_q;

  logic [LenW-1:0]        len_q, len_d;
  logic [MAX_PATTERN-1:0] used_q, used_d;
  logic [MAX_PATTERN:0]   active_q, active_d;
  logic                   ovf_q, ovf_d;
  logic                   fresh_q, fresh_d;

  logic out_valid_q, out_valid_d;
  logic out_match_q, out_ovf_q;

  logic fire, out_free, full, hit;
  logic [MAX_PATTERN:0]   act_base, act_cl, act_next;
  logic [MAX_PATTERN-1:0] hop, step;
  gwm_cell_t              cells [MAX_PATTERN];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && ((in_op_q != OP_END) || out_free);
  assign s_axis_tready = !in_valid_q || fire;
  assign full          = (len_q == LenW'(MAX_PATTERN));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q  <= gwm_op_e'(s_axis_tuser);
      in_sym_q <= s_axis_tdata;
    end
  end

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic we;
    assign we = fire && (in_op_q == OP_APPEND) && !full && (len_q == LenW'(i));
    gwm_cell u_cell (
      .clk_i      (clk_i),
      .we_i       (we),
      .wr_sym_i   (in_sym_q),
      .subj_sym_i (in_sym_q),
      .cell_o     (cells[i])
    );
    assign hop[i]  = used_q[i] && cells[i].star;
    assign step[i] = used_q[i] && !cells[i].star && cells[i].step_ok;
  end

  assign act_base = fresh_q ? (MAX_PATTERN+1)'(1) : active_q;

  gwm_closure #(
    .Depth (MAX_PATTERN)
  ) u_closure (
    .act_i (act_base),
    .hop_i (hop),
    .act_o (act_cl)
  );

  assign act_next = {1'b0, act_cl[MAX_PATTERN-1:0] & hop}
                  | {act_cl[MAX_PATTERN-1:0] & step, 1'b0};
  assign hit      = act_cl[len_q] && !ovf_q;

  always_comb begin
    len_d       = len_q;
    used_d      = used_q;
    active_d    = active_q;
    ovf_d       = ovf_q;
    fresh_d     = fresh_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (fire) begin
      case (in_op_q)
        OP_CLEAR: begin
          len_d   = '0;
          used_d  = '0;
          ovf_d   = 1'b0;
          fresh_d = 1'b1;
        end
        OP_APPEND: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            len_d  = len_q + LenW'(1);
            used_d = used_q | (MAX_PATTERN'(1) << len_q);
          end
          fresh_d = 1'b1;
        end
        OP_SUBJECT: begin
          active_d = act_next;
          fresh_d  = 1'b0;
        end
        OP_END: begin
          fresh_d     = 1'b1;
          out_valid_d = 1'b1;
        end
        default: begin
          fresh_d = fresh_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      used_q      <= '0;
      active_q    <= (MAX_PATTERN+1)'(1);
      ovf_q       <= 1'b0;
      fresh_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      used_q      <= used_d;
      active_q    <= active_d;
      ovf_q       <= ovf_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && (in_op_q == OP_END)) begin
      out_match_q <= hit;
      out_ovf_q   <= ovf_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_match_q};
  assign m_axis_tuser  = out_ovf_q;

  `GWM_ASSERT(a_len_range, len_q <= LenW'(MAX_PATTERN), "pattern length past capacity")
  `GWM_ASSERT(a_used_count, $countones(used_q) == int'(len_q), "cell valid mask out of step with length")
  `GWM_ASSERT(a_ovf_nomatch, !(m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata[0]), "match reported on overflow")
  `GWM_ASSERT_NEXT(a_end_result, fire && (in_op_q == OP_END), out_valid_q, "end-of-subject beat lost its result")

endmodule
`default_nettype wire
